[rtl/um32_pkg.sv]
// Shared types and constants for the UM32 register execute unit.
package um32_pkg;

    localparam int unsigned NUM_REGS   = 8;
    localparam int unsigned REG_IDX_W  = $clog2(NUM_REGS);
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned IMM_W      = 25;
    localparam int unsigned CHAR_W     = 9;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned OP_W       = 4;
    localparam int unsigned DIV_CNT_W  = $clog2(WORD_W);

    typedef enum logic [OP_W-1:0] {
        OP_CMOV    = 4'd0,
        OP_SEG_LD  = 4'd1,
        OP_SEG_ST  = 4'd2,
        OP_ADD     = 4'd3,
        OP_MUL     = 4'd4,
        OP_DIV     = 4'd5,
        OP_NAND    = 4'd6,
        OP_HALT    = 4'd7,
        OP_MAP     = 4'd8,
        OP_UNMAP   = 4'd9,
        OP_OUT     = 4'd10,
        OP_IN      = 4'd11,
        OP_LOADPRG = 4'd12,
        OP_LOADVAL = 4'd13
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
        logic div_step;
        logic commit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_div;
        logic div_last;
    } t_dp_status;

endpackage

[rtl/um32_dp.sv]
// Datapath: register file, ALU, iterative divider, halt flag and result payload.
module um32_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  um32_pkg::t_dp_cmd                 i_cmd,
    output um32_pkg::t_dp_status              o_status,
    input  logic [um32_pkg::OP_W-1:0]         i_action,
    input  logic [um32_pkg::REG_IDX_W-1:0]    i_reg_a,
    input  logic [um32_pkg::REG_IDX_W-1:0]    i_reg_b,
    input  logic [um32_pkg::REG_IDX_W-1:0]    i_reg_c,
    input  logic [um32_pkg::IMM_W-1:0]        i_immediate,
    input  logic [um32_pkg::CHAR_W-1:0]       i_input_char,
    output logic                              o_out_valid,
    output logic [um32_pkg::BYTE_W-1:0]       o_out_byte,
    output logic                              o_halted,
    output logic                              o_unsupported
);
    import um32_pkg::*;

    // Register file and per-entry valid bits; an entry never written reads as zero.
    logic [WORD_W-1:0]    r_mem [NUM_REGS];
    logic [NUM_REGS-1:0]  r_mem_vld;

    // Latched instruction and operands.
    t_op                  r_op;
    logic [REG_IDX_W-1:0] r_a;
    logic [REG_IDX_W-1:0] r_c;
    logic [IMM_W-1:0]     r_imm;
    logic [CHAR_W-1:0]    r_ch;
    logic [WORD_W-1:0]    r_vb;
    logic [WORD_W-1:0]    r_vc;

    // Staged write-back and result.
    logic [WORD_W-1:0]    r_wb_data, n_wb_data;
    logic                 r_wb_en, n_wb_en;
    logic [REG_IDX_W-1:0] r_wb_addr, n_wb_addr;
    logic                 r_res_out, n_res_out;
    logic [BYTE_W-1:0]    r_res_byte, n_res_byte;
    logic                 r_res_unsup, n_res_unsup;
    logic                 r_halt_set, n_halt_set;
    logic                 r_halt;

    // Restoring divider.
    logic [WORD_W-1:0]    r_rem;
    logic [WORD_W-1:0]    r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [WORD_W:0]      div_shift;
    logic [WORD_W:0]      div_diff;
    logic                 div_bit;
    logic [WORD_W-1:0]    mul_lo;

    assign div_shift = {r_rem, r_quo[WORD_W-1]};
    assign div_diff  = div_shift - {1'b0, r_vc};
    assign div_bit   = ~div_diff[WORD_W];
    assign mul_lo    = WORD_W'(r_vb * r_vc);

    assign o_status.need_div = (r_op == OP_DIV) && !r_halt && (r_vc != '0);
    assign o_status.div_last = (r_cnt == DIV_CNT_W'(WORD_W - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= t_op'(i_action);
            r_a   <= i_reg_a;
            r_c   <= i_reg_c;
            r_imm <= i_immediate;
            r_ch  <= i_input_char;
            r_vb  <= r_mem_vld[i_reg_b] ? r_mem[i_reg_b] : '0;
            r_vc  <= r_mem_vld[i_reg_c] ? r_mem[i_reg_c] : '0;
        end
        if (i_cmd.commit && r_wb_en) begin
            r_mem[r_wb_addr] <= r_wb_data;
        end
    end

    always_comb begin
        n_wb_data   = '0;
        n_wb_en     = 1'b0;
        n_wb_addr   = r_a;
        n_res_out   = 1'b0;
        n_res_byte  = '0;
        n_res_unsup = 1'b0;
        n_halt_set  = 1'b0;
        if (!r_halt) begin
            case (r_op)
                OP_CMOV: begin
                    n_wb_data = r_vb;
                    n_wb_en   = (r_vc != '0);
                end
                OP_ADD: begin
                    n_wb_data = r_vb + r_vc;
                    n_wb_en   = 1'b1;
                end
                OP_MUL: begin
                    n_wb_data = mul_lo;
                    n_wb_en   = 1'b1;
                end
                OP_DIV: begin
                    // A zero divisor writes all ones; otherwise the divider fills this in.
                    n_wb_data = '1;
                    n_wb_en   = 1'b1;
                end
                OP_NAND: begin
                    n_wb_data = ~(r_vb & r_vc);
                    n_wb_en   = 1'b1;
                end
                OP_HALT: begin
                    n_halt_set = 1'b1;
                end
                OP_OUT: begin
                    n_res_out  = 1'b1;
                    n_res_byte = r_vc[BYTE_W-1:0];
                end
                OP_IN: begin
                    n_wb_addr = r_c;
                    n_wb_en   = 1'b1;
                    n_wb_data = r_ch[CHAR_W-1] ? '1 : WORD_W'(r_ch);
                end
                OP_LOADVAL: begin
                    n_wb_addr = r_c;
                    n_wb_en   = 1'b1;
                    n_wb_data = WORD_W'(r_imm);
                end
                default: begin
                    n_res_unsup = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_wb_data   <= n_wb_data;
            r_wb_en     <= n_wb_en;
            r_wb_addr   <= n_wb_addr;
            r_res_out   <= n_res_out;
            r_res_byte  <= n_res_byte;
            r_res_unsup <= n_res_unsup;
            r_halt_set  <= n_halt_set;
            r_rem       <= '0;
            r_quo       <= r_vb;
            r_cnt       <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= div_bit ? div_diff[WORD_W-1:0] : div_shift[WORD_W-1:0];
            r_quo <= {r_quo[WORD_W-2:0], div_bit};
            r_cnt <= r_cnt + 1'b1;
            if (o_status.div_last) begin
                r_wb_data <= {r_quo[WORD_W-2:0], div_bit};
            end
        end
        if (i_cmd.commit) begin
            o_out_valid   <= r_res_out;
            o_out_byte    <= r_res_byte;
            o_unsupported <= r_res_unsup;
            o_halted      <= r_halt | r_halt_set;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_vld <= '0;
            r_halt    <= 1'b0;
        end else if (i_cmd.commit) begin
            if (r_wb_en) begin
                r_mem_vld[r_wb_addr] <= 1'b1;
            end
            if (r_halt_set) begin
                r_halt <= 1'b1;
            end
        end
    end

endmodule

[rtl/um32_ctrl.sv]
// Controller: sequences accept, execute, divide and commit, and owns the output valid.
module um32_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    output logic                    o_valid,
    input  logic                    i_ready,
    output um32_pkg::t_dp_cmd       o_cmd,
    input  um32_pkg::t_dp_status    i_status
);
    import um32_pkg::*;

    t_state r_state, n_state;
    logic   r_res_valid, n_res_valid;
    logic   slot_free;

    assign slot_free = !r_res_valid || i_ready;
    assign o_valid   = r_res_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_ready      = 1'b0;
        o_cmd        = '0;
        n_res_valid  = r_res_valid && !i_ready;
        case (r_state)
            ST_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
                if (i_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_status.need_div ? ST_DIV : ST_DONE;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // The result waits here until the output register has room.
                if (slot_free) begin
                    o_cmd.commit = 1'b1;
                    n_res_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/um32_register_execute_unit_core.sv]
// Top level of the UM32 register execute unit.
//
// Usage: one decoded instruction is taken per input transaction (i_valid and
// o_ready high at a clock edge) and exactly one result transaction follows
// on the output channel (o_valid and i_ready high), carrying the output byte
// flag, the byte, the halt flag and the unsupported flag.
// After acceptance an instruction passes through the execute state and the done
// state, from which its result is committed to the output register; a division by
// a non-zero divisor runs the divide state in between, as the quotient comes from a
// restoring divider that resolves one bit per cycle. One instruction is in flight
// at a time, so the next is taken only once the previous result has left the done
// state, while that result may still wait in the output register.
// Reset (synchronous, active low) clears the register file to zero, the halt
// flag and all handshake state. When the receiver stalls, the finished result
// of the following instruction waits inside the block and no further
// instruction is taken until the output register drains.
module um32_register_execute_unit_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [um32_pkg::OP_W-1:0]         i_action,
    input  logic [um32_pkg::REG_IDX_W-1:0]    i_reg_a,
    input  logic [um32_pkg::REG_IDX_W-1:0]    i_reg_b,
    input  logic [um32_pkg::REG_IDX_W-1:0]    i_reg_c,
    input  logic [um32_pkg::IMM_W-1:0]        i_immediate,
    input  logic [um32_pkg::CHAR_W-1:0]       i_input_char,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_out_valid,
    output logic [um32_pkg::BYTE_W-1:0]       o_out_byte,
    output logic                              o_halted,
    output logic                              o_unsupported
);
    import um32_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    um32_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_cmd    (cmd),
        .i_status (status)
    );

    um32_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_action      (i_action),
        .i_reg_a       (i_reg_a),
        .i_reg_b       (i_reg_b),
        .i_reg_c       (i_reg_c),
        .i_immediate   (i_immediate),
        .i_input_char  (i_input_char),
        .o_out_valid   (o_out_valid),
        .o_out_byte    (o_out_byte),
        .o_halted      (o_halted),
        .o_unsupported (o_unsupported)
    );

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the UM32 register execute unit core.
module testbench;
    import um32_pkg::*;

    localparam int unsigned N_RANDOM     = 1800;
    localparam int unsigned PHASE_LEN    = 150;
    localparam int unsigned MAX_SHOWN    = 10;
    localparam int unsigned END_OF_INPUT = 256;
    localparam logic [OP_W-1:0] OP_UNDEF_E = 4'd14;
    localparam logic [OP_W-1:0] OP_UNDEF_F = 4'd15;

    typedef struct {
        logic [OP_W-1:0]      action;
        logic [REG_IDX_W-1:0] reg_a;
        logic [REG_IDX_W-1:0] reg_b;
        logic [REG_IDX_W-1:0] reg_c;
        logic [IMM_W-1:0]     immediate;
        logic [CHAR_W-1:0]    input_char;
    } t_instr;

    typedef struct {
        logic              out_valid;
        logic [BYTE_W-1:0] out_byte;
        logic              halted;
        logic              unsupported;
    } t_outcome;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_valid      = 1'b0;
    logic [OP_W-1:0]      i_action     = '0;
    logic [REG_IDX_W-1:0] i_reg_a      = '0;
    logic [REG_IDX_W-1:0] i_reg_b      = '0;
    logic [REG_IDX_W-1:0] i_reg_c      = '0;
    logic [IMM_W-1:0]     i_immediate  = '0;
    logic [CHAR_W-1:0]    i_input_char = '0;
    logic                 i_ready      = 1'b0;
    logic                 o_ready;
    logic                 o_valid;
    logic                 o_out_valid;
    logic [BYTE_W-1:0]    o_out_byte;
    logic                 o_halted;
    logic                 o_unsupported;

    t_instr            instr_queue[$];
    t_outcome          pending_results[$];
    logic [WORD_W-1:0] shadow_regs [NUM_REGS];
    logic              shadow_halted;
    int unsigned       n_sent, n_checked, n_errors;
    int unsigned       n_div, n_div_zero, n_eoi, n_bytes, n_unsup;

    um32_register_execute_unit_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_action      (i_action),
        .i_reg_a       (i_reg_a),
        .i_reg_b       (i_reg_b),
        .i_reg_c       (i_reg_c),
        .i_immediate   (i_immediate),
        .i_input_char  (i_input_char),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_valid   (o_out_valid),
        .o_out_byte    (o_out_byte),
        .o_halted      (o_halted),
        .o_unsupported (o_unsupported)
    );

    always #6 i_clk = ~i_clk;

    // Applies one instruction to the shadow register file and returns the result it yields.
    function automatic t_outcome execute_instr(t_instr ins);
        t_outcome          res;
        logic [WORD_W-1:0] vb;
        logic [WORD_W-1:0] vc;
        res.out_valid   = 1'b0;
        res.out_byte    = '0;
        res.unsupported = 1'b0;
        vb = shadow_regs[ins.reg_b];
        vc = shadow_regs[ins.reg_c];
        if (!shadow_halted) begin
            case (ins.action)
                OP_CMOV: begin
                    if (vc != '0) shadow_regs[ins.reg_a] = vb;
                end
                OP_ADD:  shadow_regs[ins.reg_a] = vb + vc;
                OP_MUL:  shadow_regs[ins.reg_a] = vb * vc;
                OP_DIV: begin
                    n_div++;
                    if (vc == '0) n_div_zero++;
                    shadow_regs[ins.reg_a] = (vc == '0) ? '1 : vb / vc;
                end
                OP_NAND: shadow_regs[ins.reg_a] = ~(vb & vc);
                OP_HALT: shadow_halted = 1'b1;
                OP_OUT: begin
                    n_bytes++;
                    res.out_valid = 1'b1;
                    res.out_byte  = vc[BYTE_W-1:0];
                end
                OP_IN: begin
                    if (ins.input_char >= END_OF_INPUT) begin
                        n_eoi++;
                        shadow_regs[ins.reg_c] = '1;
                    end else begin
                        shadow_regs[ins.reg_c] = WORD_W'(ins.input_char);
                    end
                end
                OP_LOADVAL: shadow_regs[ins.reg_c] = WORD_W'(ins.immediate);
                default: begin
                    n_unsup++;
                    res.unsupported = 1'b1;
                end
            endcase
        end
        res.halted = shadow_halted;
        return res;
    endfunction

    // Phases of 150 transactions rotate: no idling, sender idle, receiver stalling, both.
    function automatic int unsigned idle_pct(int unsigned count, bit receiver);
        int unsigned phase;
        phase = (count / PHASE_LEN) % 4;
        if (phase == 3) return 16;
        if (receiver) return (phase == 2) ? 70 : 0;
        return (phase == 1) ? 70 : 0;
    endfunction

    function automatic bit roll(int unsigned pct);
        return $urandom_range(99) < pct;
    endfunction

    task automatic queue_instr(input logic [OP_W-1:0] op, input int unsigned a, b, c,
                               input int unsigned imm, ch);
        t_instr ins;
        ins.action     = op;
        ins.reg_a      = REG_IDX_W'(a);
        ins.reg_b      = REG_IDX_W'(b);
        ins.reg_c      = REG_IDX_W'(c);
        ins.immediate  = IMM_W'(imm);
        ins.input_char = CHAR_W'(ch);
        instr_queue.push_back(ins);
    endtask

    function automatic t_instr random_instr();
        t_instr          ins;
        int unsigned     pick;
        logic [OP_W-1:0] unsup_ops [7];
        unsup_ops = '{OP_SEG_LD, OP_SEG_ST, OP_MAP, OP_UNMAP, OP_LOADPRG,
                      OP_UNDEF_E, OP_UNDEF_F};
        pick = $urandom_range(99);
        if (pick < 15)      ins.action = OP_LOADVAL;
        else if (pick < 25) ins.action = OP_IN;
        else if (pick < 37) ins.action = OP_ADD;
        else if (pick < 47) ins.action = OP_MUL;
        else if (pick < 59) ins.action = OP_DIV;
        else if (pick < 71) ins.action = OP_NAND;
        else if (pick < 81) ins.action = OP_CMOV;
        else if (pick < 94) ins.action = OP_OUT;
        else                ins.action = unsup_ops[$urandom_range(6)];
        ins.reg_a = REG_IDX_W'($urandom);
        ins.reg_b = REG_IDX_W'($urandom);
        ins.reg_c = REG_IDX_W'($urandom);
        // Small immediates give divisors and bytes of interest; wide ones reach the top bits.
        pick = $urandom_range(99);
        if (pick < 40)      ins.immediate = IMM_W'($urandom_range(0, 300));
        else if (pick < 45) ins.immediate = '1;
        else                ins.immediate = IMM_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 80)      ins.input_char = CHAR_W'($urandom_range(0, 255));
        else if (pick < 90) ins.input_char = CHAR_W'(END_OF_INPUT);
        else                ins.input_char = CHAR_W'($urandom_range(257, 511));
        return ins;
    endfunction

    always @(posedge i_clk) begin : drive
        t_instr ins;
        bit     load_next;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            load_next = !i_valid;
            if (i_valid && o_ready) begin
                ins = instr_queue.pop_front();
                pending_results.push_back(execute_instr(ins));
                n_sent++;
                load_next = 1'b1;
            end
            if (load_next) begin
                if (instr_queue.size() != 0 && !roll(idle_pct(n_sent, 1'b0))) begin
                    ins = instr_queue[0];
                    i_valid      <= 1'b1;
                    i_action     <= ins.action;
                    i_reg_a      <= ins.reg_a;
                    i_reg_b      <= ins.reg_b;
                    i_reg_c      <= ins.reg_c;
                    i_immediate  <= ins.immediate;
                    i_input_char <= ins.input_char;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : observe
        t_outcome want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (pending_results.size() == 0) begin
                    n_errors++;
                    if (n_errors <= MAX_SHOWN)
                        $display("ERROR: result with nothing outstanding: out_valid=%0b byte=%02h halted=%0b unsupported=%0b",
                                 o_out_valid, o_out_byte, o_halted, o_unsupported);
                end else begin
                    want = pending_results.pop_front();
                    n_checked++;
                    if (o_out_valid !== want.out_valid || o_out_byte !== want.out_byte ||
                        o_halted !== want.halted || o_unsupported !== want.unsupported) begin
                        n_errors++;
                        if (n_errors <= MAX_SHOWN)
                            $display("ERROR: result %0d expected out_valid=%0b byte=%02h halted=%0b unsupported=%0b, got %0b %02h %0b %0b",
                                     n_checked, want.out_valid, want.out_byte, want.halted,
                                     want.unsupported, o_out_valid, o_out_byte, o_halted,
                                     o_unsupported);
                    end
                end
            end
            i_ready <= !roll(idle_pct(n_checked, 1'b1));
        end
    end

    initial begin : sequencer
        foreach (shadow_regs[i]) shadow_regs[i] = '0;
        shadow_halted = 1'b0;

        // Field extremes and the end-of-input marker.
        queue_instr(OP_LOADVAL, 0, 0, 0, 32'h1FF_FFFF, 0);
        queue_instr(OP_LOADVAL, 7, 7, 1, 0, 0);
        queue_instr(OP_IN, 0, 0, 2, 0, 0);
        queue_instr(OP_IN, 0, 0, 3, 0, 255);
        queue_instr(OP_IN, 0, 0, 4, 0, END_OF_INPUT);
        queue_instr(OP_IN, 0, 0, 5, 0, 511);
        // Output of a wide value emits only its low byte.
        queue_instr(OP_OUT, 0, 0, 4, 0, 0);
        queue_instr(OP_OUT, 7, 7, 0, 0, 0);
        queue_instr(OP_ADD, 6, 4, 0, 0, 0);
        queue_instr(OP_MUL, 7, 4, 4, 0, 0);
        queue_instr(OP_DIV, 6, 4, 3, 0, 0);
        // Division by zero writes all ones.
        queue_instr(OP_DIV, 7, 0, 1, 0, 0);
        queue_instr(OP_NAND, 1, 4, 0, 0, 0);
        queue_instr(OP_CMOV, 2, 0, 1, 0, 0);
        queue_instr(OP_LOADVAL, 0, 0, 5, 0, 0);
        queue_instr(OP_CMOV, 3, 0, 5, 0, 0);
        queue_instr(OP_OUT, 0, 0, 3, 0, 0);
        queue_instr(OP_SEG_LD, 1, 2, 3, 0, 0);
        queue_instr(OP_SEG_ST, 4, 5, 6, 0, 0);
        queue_instr(OP_MAP, 7, 0, 1, 0, 0);
        queue_instr(OP_UNMAP, 2, 3, 4, 0, 0);
        queue_instr(OP_LOADPRG, 5, 6, 7, 0, 0);
        queue_instr(OP_UNDEF_E, 0, 1, 2, 0, 0);
        queue_instr(OP_UNDEF_F, 3, 4, 5, 0, 0);

        repeat (N_RANDOM) instr_queue.push_back(random_instr());

        // A halt follows the random run; everything queued after it is ignored.
        queue_instr(OP_HALT, 0, 0, 0, 0, 0);
        queue_instr(OP_OUT, 0, 0, 4, 0, 0);
        queue_instr(OP_IN, 0, 0, 1, 0, 65);
        queue_instr(OP_LOADVAL, 0, 0, 3, 12345, 0);
        queue_instr(OP_DIV, 1, 2, 3, 0, 0);
        queue_instr(OP_UNDEF_F, 0, 0, 0, 0, 0);
        queue_instr(OP_HALT, 0, 0, 0, 0, 0);
        queue_instr(OP_OUT, 0, 0, 3, 0, 0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (instr_queue.size() != 0 || pending_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("Ran %0d instructions: %0d divisions (%0d by zero), %0d end-of-input reads, %0d bytes out, %0d unsupported.",
                 n_sent, n_div, n_div_zero, n_eoi, n_bytes, n_unsup);
        $display("Checked %0d results, %0d mismatches.", n_checked, n_errors);
        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("um32_register_execute_unit_core regression: pass");
        end else begin
            $display("um32_register_execute_unit_core regression: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #(10_000_000);
        $display("Timed out with %0d results outstanding.", pending_results.size());
        $display("um32_register_execute_unit_core regression: fail");
        $finish;
    end

endmodule
